### src/apd_pkg.sv
// Shared types, constants and arithmetic helpers for the allpass delay filter.
// No dependencies.
package apd_pkg;

    localparam int DATA_W        = 16;
    localparam int DELAY_W       = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DEF_MAX_DELAY = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

    // +-0.999 in Q1.15
    localparam logic signed [DATA_W-1:0] GAIN_LIMIT = 16'sd32735;
    localparam logic signed [31:0]       ROUND_BIAS = 32'sd16384;

    typedef struct packed {
        logic signed [DATA_W-1:0] w;   // value written back to the line
        logic signed [DATA_W-1:0] y;   // filter output
    } t_arith_res;

    // round(p / 2^15), ties toward +inf; |p| < 2^30 so 32 bits hold the bias add
    function automatic logic signed [16:0] q15_round(input logic signed [31:0] p);
        logic signed [31:0] s;
        s = p + ROUND_BIAS;
        return s[31:15];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/allpass_delay_filter.sv
// Allpass delay filter top: read pointer, two-stage word pipeline, output register.
// Stage 1 holds each accepted word and line read; the output register takes the result.
// Throughput: 1 word per cycle unless the output stalls or the clear sweep runs, set by
// the single write port of the delay memory. Reset: config returns to delay 1, gain 0;
// then a sweep zeroes all MAX_DELAY entries; input words wait, config writes do not.
// Depends on apd_pkg, apd_cfg, apd_line, apd_arith.
module allpass_delay_filter
    import apd_pkg::*;
#(
    parameter int MAX_DELAY = DEF_MAX_DELAY,
    localparam int AW = $clog2(MAX_DELAY)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input words
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_sample_in,
    // output words
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_sample_out,
    // config writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [AW:0]   DEPTH = (AW+1)'(MAX_DELAY);
    localparam logic [AW-1:0] LAST  = AW'(MAX_DELAY - 1);

    logic [AW-1:0]            delay;
    logic signed [DATA_W-1:0] gain;
    logic                     busy;
    logic signed [DATA_W-1:0] rd_data;
    t_arith_res               res;

    // pointer and pipeline registers
    logic [AW-1:0]            r_rp;
    logic                     r_s1_valid;
    logic signed [DATA_W-1:0] r_s1_x;
    logic [AW-1:0]            r_s1_wa;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_y;

    logic                     in_accept;
    logic                     s1_adv;
    logic [AW:0]              wa_sum;
    logic [AW-1:0]            wa;

    apd_cfg #(.MAX_DELAY(MAX_DELAY)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_delay     (delay),
        .o_gain      (gain)
    );

    // stage 1 word leaves (and writes back) when the output slot is free or drains
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !busy && (!r_s1_valid || s1_adv);
    assign in_accept  = i_in_valid && o_in_ready;

    // write position = rp + delay, wrapped; sum stays below twice the depth
    assign wa_sum = {1'b0, r_rp} + {1'b0, delay};
    assign wa     = (wa_sum >= DEPTH) ? AW'(wa_sum - DEPTH) : wa_sum[AW-1:0];

    // read at accept, write back when stage 1 advances; the line bypasses
    // the case where a new word reads the entry being written on that edge
    apd_line #(.MAX_DELAY(MAX_DELAY)) u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_rp),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_wa),
        .i_wr_data (res.w),
        .o_rd_data (rd_data),
        .o_busy    (busy)
    );

    apd_arith u_arith (
        .i_x   (r_s1_x),
        .i_d   (rd_data),
        .i_g   (gain),
        .o_res (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_x  <= i_sample_in;
            r_s1_wa <= wa;
        end
        if (s1_adv) begin
            r_out_y <= res.y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_y;

endmodule

### src/apd_cfg.sv
// Configuration registers (delay, gain) with range clamping on write.
// Depends on apd_pkg.
module apd_cfg
    import apd_pkg::*;
#(
    parameter int MAX_DELAY = DEF_MAX_DELAY,
    localparam int AW = $clog2(MAX_DELAY)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic [AW-1:0]                o_delay,
    output logic signed [DATA_W-1:0]     o_gain
);

    localparam logic [16:0] DELAY_MAX = 17'(MAX_DELAY - 1);

    logic [AW-1:0]            r_delay, n_delay;
    logic signed [DATA_W-1:0] r_gain, n_gain;
    logic [16:0]              delay_raw;
    logic signed [DATA_W-1:0] gain_raw;

    assign o_cfg_ready = 1'b1;
    assign delay_raw   = 17'(i_cfg_data[DELAY_W-1:0]);
    assign gain_raw    = i_cfg_data;

    always_comb begin
        n_delay = r_delay;
        n_gain  = r_gain;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DELAY: begin
                    if (delay_raw == 17'd0) begin
                        n_delay = AW'(1);
                    end else if (delay_raw > DELAY_MAX) begin
                        n_delay = DELAY_MAX[AW-1:0];
                    end else begin
                        n_delay = delay_raw[AW-1:0];
                    end
                end
                REG_GAIN: begin
                    if (gain_raw > GAIN_LIMIT) begin
                        n_gain = GAIN_LIMIT;
                    end else if (gain_raw < -GAIN_LIMIT) begin
                        n_gain = -GAIN_LIMIT;
                    end else begin
                        n_gain = gain_raw;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= AW'(1);
            r_gain  <= '0;
        end else begin
            r_delay <= n_delay;
            r_gain  <= n_gain;
        end
    end

    assign o_delay = r_delay;
    assign o_gain  = r_gain;

endmodule

### src/apd_line.sv
// Delay line memory: one write and one registered read port, clear sweep after
// reset, and read-during-write bypass. Depends on apd_pkg.
module apd_line
    import apd_pkg::*;
#(
    parameter int MAX_DELAY = DEF_MAX_DELAY,
    localparam int AW = $clog2(MAX_DELAY)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    output logic signed [DATA_W-1:0] o_rd_data,
    output logic                     o_busy
);

    localparam logic [AW-1:0] LAST = AW'(MAX_DELAY - 1);

    logic signed [DATA_W-1:0] mem [MAX_DELAY];
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [DATA_W-1:0] r_fwd_data;
    logic                     r_fwd;
    logic                     r_clr_busy;
    logic [AW-1:0]            r_clr_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    // sweep owns the write port until done; no words enter meanwhile
    assign wr_en   = r_clr_busy | i_wr_en;
    assign wr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign wr_data = r_clr_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // same-edge read/write to one entry: memory returns old data, bypass it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

### src/apd_arith.sv
// Allpass arithmetic: feedback write value and output, both rounded and saturated.
// Depends on apd_pkg.
module apd_arith
    import apd_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_d,
    input  logic signed [DATA_W-1:0] i_g,
    output t_arith_res               o_res
);

    logic signed [31:0] prod_d;
    logic signed [31:0] prod_x;
    logic signed [16:0] rnd_d;
    logic signed [16:0] rnd_x;

    assign prod_d = i_d * i_g;
    assign prod_x = i_x * i_g;
    assign rnd_d  = q15_round(prod_d);
    assign rnd_x  = q15_round(prod_x);

    assign o_res.w = sat16(18'(i_x) - 18'(rnd_d));
    assign o_res.y = sat16(18'(i_d) + 18'(rnd_x));

endmodule
